// ===== rtl/pfcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proof frame parser package
// Result kinds, status codes, the result item layout and record constants.
// ----------------------------------------------------------------------------
package pfcp_pkg;

    localparam int unsigned HDR_BYTES = 28;
    localparam int unsigned PLEN_BYTES = 4;

    typedef enum logic [3:0] {
        KIND_FLAGS     = 4'd0,
        KIND_SYSTEM_ID = 4'd1,
        KIND_STMT_VER  = 4'd2,
        KIND_PROOF_LEN = 4'd3,
        KIND_DIGEST    = 4'd4,
        KIND_BINDING   = 4'd5,
        KIND_COMMIT    = 4'd6,
        KIND_PROOF     = 4'd7,
        KIND_STATUS    = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_MAGIC    = 3'd2,
        ST_BAD_HDR_LEN  = 3'd3,
        ST_TOTAL_MISM   = 3'd4,
        ST_PLEN_MISM    = 3'd5,
        ST_RESERVED_NZ  = 3'd6
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [31:0] index;
        status_t     status;
    } item_t;

endpackage

// ===== rtl/pfcp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proof frame parser front end
// Tracks the byte position, assembles header words, runs the record checks
// and classifies each accepted byte into at most one result item.
// ----------------------------------------------------------------------------
module pfcp_front
    import pfcp_pkg::*;
#(
    parameter int unsigned HASH_BYTES     = 32,
    parameter int unsigned RESERVED_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        is_final,
    input  logic [31:0] expected_magic,
    input  logic [31:0] expected_version,
    output logic        item_valid,
    output item_t       item
);

    localparam logic [31:0] POS_DIGEST  = 32'(HDR_BYTES);
    localparam logic [31:0] POS_BINDING = 32'(HDR_BYTES + HASH_BYTES);
    localparam logic [31:0] POS_COMMIT  = 32'(HDR_BYTES + 2 * HASH_BYTES);
    localparam logic [31:0] POS_PLEN    = 32'(HDR_BYTES + 3 * HASH_BYTES);
    localparam logic [31:0] POS_PLEN_LAST = 32'(HDR_BYTES + 3 * HASH_BYTES + PLEN_BYTES - 1);
    localparam logic [31:0] POS_PROOF   = 32'(HDR_BYTES + 3 * HASH_BYTES + PLEN_BYTES);
    localparam logic [31:0] MIN_LEN     =
        32'(HDR_BYTES + 3 * HASH_BYTES + PLEN_BYTES + RESERVED_BYTES);
    localparam logic [32:0] PROOF_END_RST = 33'(POS_PROOF);
    localparam logic [32:0] WANT_RST      = 33'(MIN_LEN);
    localparam logic [31:0] HDR_LEN_WORD  = 32'(HDR_BYTES);

    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic        mv_bad_reg, mv_bad_next;
    logic        hl_bad_reg, hl_bad_next;
    logic [31:0] total_reg, total_next;
    logic [32:0] proof_end_reg, proof_end_next;
    logic [32:0] want_reg, want_next;
    logic        trailer_nz_reg, trailer_nz_next;
    logic [31:0] proof_off;

    always_comb
    begin
        shift_next      = {in_byte, shift_reg[31:8]};
        pos_next        = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;
        mv_bad_next     = mv_bad_reg;
        hl_bad_next     = hl_bad_reg;
        total_next      = total_reg;
        proof_end_next  = proof_end_reg;
        want_next       = want_reg;
        trailer_nz_next = trailer_nz_reg;
        proof_off       = pos_reg - POS_PROOF;
        item_valid      = 1'b0;
        item.kind       = KIND_FLAGS;
        item.value      = 32'd0;
        item.index      = 32'd0;
        item.status     = ST_OK;

        if (pos_reg < POS_DIGEST)
        begin
            if (pos_reg[1:0] == 2'b11)
            begin
                unique case (pos_reg[4:2])
                    3'd0:
                    begin
                        if (shift_next != expected_magic)
                            mv_bad_next = 1'b1;
                    end
                    3'd1:
                    begin
                        if (shift_next != expected_version)
                            mv_bad_next = 1'b1;
                    end
                    3'd2:
                    begin
                        item_valid = 1'b1;
                        item.kind  = KIND_FLAGS;
                        item.value = shift_next;
                    end
                    3'd3:
                    begin
                        if (shift_next != HDR_LEN_WORD)
                            hl_bad_next = 1'b1;
                    end
                    3'd4:
                    begin
                        total_next = shift_next;
                    end
                    3'd5:
                    begin
                        item_valid = 1'b1;
                        item.kind  = KIND_SYSTEM_ID;
                        item.value = shift_next;
                    end
                    default:
                    begin
                        item_valid = 1'b1;
                        item.kind  = KIND_STMT_VER;
                        item.value = shift_next;
                    end
                endcase
            end
        end
        else if (pos_reg < POS_BINDING)
        begin
            item_valid = 1'b1;
            item.kind  = KIND_DIGEST;
            item.value = {24'd0, in_byte};
            item.index = pos_reg - POS_DIGEST;
        end
        else if (pos_reg < POS_COMMIT)
        begin
            item_valid = 1'b1;
            item.kind  = KIND_BINDING;
            item.value = {24'd0, in_byte};
            item.index = pos_reg - POS_BINDING;
        end
        else if (pos_reg < POS_PLEN)
        begin
            item_valid = 1'b1;
            item.kind  = KIND_COMMIT;
            item.value = {24'd0, in_byte};
            item.index = pos_reg - POS_COMMIT;
        end
        else if (pos_reg < POS_PROOF)
        begin
            if (pos_reg == POS_PLEN_LAST)
            begin
                // Keep the proof end and the expected record length ready
                // so that later bytes only need a compare.
                proof_end_next = {1'b0, shift_next} + PROOF_END_RST;
                want_next      = {1'b0, shift_next} + WANT_RST;
                item_valid     = 1'b1;
                item.kind      = KIND_PROOF_LEN;
                item.value     = shift_next;
            end
        end
        else if ({1'b0, pos_reg} < proof_end_reg)
        begin
            item_valid = 1'b1;
            item.kind  = KIND_PROOF;
            item.value = {24'd0, in_byte};
            item.index = proof_off;
        end
        else if (in_byte != 8'd0)
        begin
            trailer_nz_next = 1'b1;
        end

        if (is_final)
        begin
            item_valid  = 1'b1;
            item.kind   = KIND_STATUS;
            item.value  = 32'd0;
            item.index  = 32'd0;
            priority if (pos_next < MIN_LEN)
                item.status = ST_TOO_SHORT;
            else if (mv_bad_next)
                item.status = ST_BAD_MAGIC;
            else if (hl_bad_next)
                item.status = ST_BAD_HDR_LEN;
            else if (total_reg != pos_next)
                item.status = ST_TOTAL_MISM;
            else if ({1'b0, pos_next} != want_reg)
                item.status = ST_PLEN_MISM;
            else if (trailer_nz_next)
                item.status = ST_RESERVED_NZ;
            else
                item.status = ST_OK;

            pos_next        = 32'd0;
            shift_next      = 32'd0;
            mv_bad_next     = 1'b0;
            hl_bad_next     = 1'b0;
            total_next      = 32'd0;
            proof_end_next  = PROOF_END_RST;
            want_next       = WANT_RST;
            trailer_nz_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 32'd0;
            shift_reg      <= 32'd0;
            mv_bad_reg     <= 1'b0;
            hl_bad_reg     <= 1'b0;
            total_reg      <= 32'd0;
            proof_end_reg  <= PROOF_END_RST;
            want_reg       <= WANT_RST;
            trailer_nz_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            mv_bad_reg     <= mv_bad_next;
            hl_bad_reg     <= hl_bad_next;
            total_reg      <= total_next;
            proof_end_reg  <= proof_end_next;
            want_reg       <= want_next;
            trailer_nz_reg <= trailer_nz_next;
        end
    end

endmodule

// ===== rtl/pfcp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proof frame parser result queue
// Short register queue between the front end and the output port.
// ----------------------------------------------------------------------------
module pfcp_queue
    import pfcp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  not_full,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int unsigned AW = $clog2(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             pop;

    assign not_full  = (count_reg != (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/proof_frame_checking_parser.sv =====
`timescale 1ns / 1ps
// Result path: each result beat is registered in the result queue as its byte is accepted.
// Throughput: one byte per cycle; the slave side stalls only when the four-entry
// result queue is full, which a master side taking one beat per cycle never causes.
// Reset: clears the record state and the queue, expected_magic to 0 and
// expected_version to 2.
// ----------------------------------------------------------------------------
// Proof frame checking parser
// Parses a framed proof record byte by byte and emits its fields and a status.
// ----------------------------------------------------------------------------
module proof_frame_checking_parser
    import pfcp_pkg::*;
#(
    parameter int unsigned HASH_BYTES     = 32,
    parameter int unsigned RESERVED_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] value, [63:32] index, [66:64] status, rest zero
    output logic [3:0]  m_tuser,   // [3:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    logic [31:0] magic_reg, version_reg;
    logic        cfg_wr;
    logic        accept;
    logic        front_valid;
    item_t       front_item;
    item_t       out_item;
    logic        queue_not_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_VERSION) ? version_reg : magic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 32'd0;
            version_reg <= 32'd2;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MAGIC:   magic_reg   <= pwdata;
                REG_VERSION: version_reg <= pwdata;
                default:     magic_reg   <= magic_reg;
            endcase
        end
    end

    assign s_tready = queue_not_full;
    assign accept   = s_tvalid && s_tready;

    pfcp_front #(
        .HASH_BYTES     (HASH_BYTES),
        .RESERVED_BYTES (RESERVED_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .in_byte          (s_tdata),
        .is_final         (s_tlast),
        .expected_magic   (magic_reg),
        .expected_version (version_reg),
        .item_valid       (front_valid),
        .item             (front_item)
    );

    pfcp_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && front_valid),
        .push_item (front_item),
        .not_full  (queue_not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tuser = out_item.kind;
    assign m_tdata = {5'd0, out_item.status, out_item.index, out_item.value};

endmodule

// ===== bench/proof_frame_checking_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proof frame checking parser testbench
// Streams whole proof records, both well formed and broken, byte by byte into
// the parser. A built-in parse predictor works out every field beat and the
// closing status, and each output beat is checked against it in order. Both
// stream sides idle at random, and the magic and version registers are
// rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module proof_frame_checking_parser_tb;
    import pfcp_pkg::*;

    localparam int unsigned HASH = 32;
    localparam int unsigned RES = 16;
    localparam int unsigned DIGEST_AT = HDR_BYTES;
    localparam int unsigned BINDING_AT = DIGEST_AT + HASH;
    localparam int unsigned COMMIT_AT = BINDING_AT + HASH;
    localparam int unsigned PLEN_AT = COMMIT_AT + HASH;
    localparam int unsigned PROOF_AT = PLEN_AT + PLEN_BYTES;
    localparam int unsigned MIN_RECORD = PROOF_AT + RES;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    localparam int REG_MAGIC = 0;
    localparam int REG_VERSION = 1;

    localparam int WORD_MAGIC = 0;
    localparam int WORD_VERSION = 1;
    localparam int WORD_FLAGS = 2;
    localparam int WORD_HDR_LEN = 3;
    localparam int WORD_TOTAL = 4;
    localparam int WORD_SYSTEM_ID = 5;
    localparam int WORD_STMT_VER = 6;

    // Ways a generated record is damaged; the broken ones follow DEF_NONE.
    typedef enum int {
        DEF_NONE,
        DEF_SHORT,
        DEF_MAGIC,
        DEF_VERSION,
        DEF_HDR_LEN,
        DEF_TOTAL,
        DEF_PLEN_OVER,
        DEF_PLEN_UNDER,
        DEF_TRAILER_NZ,
        DEF_HUGE_PLEN,
        DEF_MULTI,
        DEF_NOISE
    } defect_t;

    typedef struct {
        defect_t     defect;
        int unsigned n_proof;
        int unsigned cut;        // nonzero truncates the record to this many bytes; noise length for DEF_NOISE
        logic [31:0] fill;       // seeds the flags, system id and statement version
        bit          has_status;
        status_t     status;
    } record_t;

    record_t frame_table [14] = '{
        '{DEF_NONE,        0, 0,              32'h0000_0000, 1'b1, ST_OK},
        '{DEF_NONE,        7, 0,              32'hFFFF_FFFF, 1'b1, ST_OK},
        '{DEF_SHORT,       0, 1,              32'h0000_0000, 1'b1, ST_TOO_SHORT},
        '{DEF_SHORT,       0, MIN_RECORD - 1, 32'hA5A5_5A5A, 1'b1, ST_TOO_SHORT},
        '{DEF_MAGIC,       3, 0,              32'h0123_4567, 1'b1, ST_BAD_MAGIC},
        '{DEF_VERSION,     3, 0,              32'h89AB_CDEF, 1'b1, ST_BAD_MAGIC},
        '{DEF_HDR_LEN,     2, 0,              32'hFFFF_0000, 1'b1, ST_BAD_HDR_LEN},
        '{DEF_TOTAL,       4, 0,              32'h0000_FFFF, 1'b1, ST_TOTAL_MISM},
        '{DEF_PLEN_OVER,   1, 0,              32'h8000_0001, 1'b1, ST_PLEN_MISM},
        '{DEF_PLEN_UNDER,  9, 0,              32'h7FFF_FFFE, 1'b1, ST_PLEN_MISM},
        '{DEF_TRAILER_NZ,  5, 0,              32'h5555_AAAA, 1'b1, ST_RESERVED_NZ},
        '{DEF_HUGE_PLEN,   6, 0,              32'hFFFF_FFFF, 1'b1, ST_PLEN_MISM},
        '{DEF_MULTI,       2, 0,              32'h0F0F_F0F0, 1'b1, ST_BAD_MAGIC},
        '{DEF_NONE,       40, 0,              32'h3C3C_C3C3, 1'b0, ST_OK}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and the running record state of the predictor.
    logic [31:0] cfg_magic = 32'd0;
    logic [31:0] cfg_version = 32'd2;
    logic [31:0] rec_pos = 32'd0;
    logic [31:0] rec_shift = 32'd0;
    logic [31:0] rec_total = 32'd0;
    logic [31:0] rec_plen = 32'd0;
    bit          rec_id_bad = 1'b0;
    bit          rec_hdr_bad = 1'b0;
    bit          rec_trail_bad = 1'b0;

    item_t       pending_fields[$];
    logic [7:0]  frame_bytes[$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    int          sink_hold = 0;
    bit          no_idle = 1'b0;

    proof_frame_checking_parser #(
        .HASH_BYTES     (HASH),
        .RESERVED_BYTES (RES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 70)
            return 0;
        if (roll < 96)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Advances the parse state by one byte; returns 1 when the byte yields a beat.
    function automatic bit predict_parse(input logic [7:0] b, input bit fin,
                                         output item_t beat);
        logic [31:0] pos;
        logic [32:0] want_len;
        status_t     st;
        bit          have;
        pos = rec_pos;
        have = 1'b0;
        beat = '{kind: KIND_FLAGS, value: 32'd0, index: 32'd0, status: ST_OK};
        rec_shift = {b, rec_shift[31:8]};
        if (pos < HDR_BYTES) begin
            if (pos[1:0] == 2'd3) begin
                case (pos[31:2])
                    WORD_MAGIC:     if (rec_shift != cfg_magic) rec_id_bad = 1'b1;
                    WORD_VERSION:   if (rec_shift != cfg_version) rec_id_bad = 1'b1;
                    WORD_FLAGS:
                    begin
                        have = 1'b1;
                        beat.kind = KIND_FLAGS;
                        beat.value = rec_shift;
                    end
                    WORD_HDR_LEN:   if (rec_shift != HDR_BYTES) rec_hdr_bad = 1'b1;
                    WORD_TOTAL:     rec_total = rec_shift;
                    WORD_SYSTEM_ID:
                    begin
                        have = 1'b1;
                        beat.kind = KIND_SYSTEM_ID;
                        beat.value = rec_shift;
                    end
                    default:
                    begin
                        have = 1'b1;
                        beat.kind = KIND_STMT_VER;
                        beat.value = rec_shift;
                    end
                endcase
            end
        end else if (pos < PLEN_AT) begin
            have = 1'b1;
            beat.value = {24'd0, b};
            if (pos < BINDING_AT) begin
                beat.kind = KIND_DIGEST;
                beat.index = pos - DIGEST_AT;
            end else if (pos < COMMIT_AT) begin
                beat.kind = KIND_BINDING;
                beat.index = pos - BINDING_AT;
            end else begin
                beat.kind = KIND_COMMIT;
                beat.index = pos - COMMIT_AT;
            end
        end else if (pos < PROOF_AT) begin
            if (pos == PROOF_AT - 1) begin
                rec_plen = rec_shift;
                have = 1'b1;
                beat.kind = KIND_PROOF_LEN;
                beat.value = rec_shift;
            end
        end else if (pos - PROOF_AT < rec_plen) begin
            have = 1'b1;
            beat.kind = KIND_PROOF;
            beat.value = {24'd0, b};
            beat.index = pos - PROOF_AT;
        end else if (b != 8'd0) begin
            rec_trail_bad = 1'b1;
        end

        if (rec_pos != 32'hFFFF_FFFF)
            rec_pos = rec_pos + 32'd1;

        if (fin) begin
            want_len = 33'(PROOF_AT) + {1'b0, rec_plen} + 33'(RES);
            if (rec_pos < MIN_RECORD)
                st = ST_TOO_SHORT;
            else if (rec_id_bad)
                st = ST_BAD_MAGIC;
            else if (rec_hdr_bad)
                st = ST_BAD_HDR_LEN;
            else if (rec_total != rec_pos)
                st = ST_TOTAL_MISM;
            else if ({1'b0, rec_pos} != want_len)
                st = ST_PLEN_MISM;
            else if (rec_trail_bad)
                st = ST_RESERVED_NZ;
            else
                st = ST_OK;
            rec_pos = 32'd0;
            rec_shift = 32'd0;
            rec_total = 32'd0;
            rec_plen = 32'd0;
            rec_id_bad = 1'b0;
            rec_hdr_bad = 1'b0;
            rec_trail_bad = 1'b0;
            beat = '{kind: KIND_STATUS, value: 32'd0, index: 32'd0, status: st};
            return 1'b1;
        end
        return have;
    endfunction

    // Lays out one record in frame_bytes, damaged as the descriptor asks.
    function automatic void build_record(input record_t r);
        logic [31:0] words [7];
        logic [31:0] plen;
        int unsigned n_trail;
        int unsigned record_len;
        frame_bytes.delete();
        if (r.defect == DEF_NOISE) begin
            repeat (r.cut) frame_bytes.push_back(8'($urandom));
            return;
        end
        plen = r.n_proof;
        n_trail = RES;
        if (r.defect == DEF_PLEN_OVER)
            n_trail = RES + $urandom_range(3, 1);
        else if (r.defect == DEF_PLEN_UNDER)
            n_trail = RES - 1;
        else if (r.defect == DEF_HUGE_PLEN)
            plen = 32'hFFFF_FFFF;
        record_len = PROOF_AT + r.n_proof + n_trail;

        words[WORD_MAGIC] = cfg_magic;
        words[WORD_VERSION] = cfg_version;
        words[WORD_FLAGS] = r.fill;
        words[WORD_HDR_LEN] = HDR_BYTES;
        words[WORD_TOTAL] = record_len;
        words[WORD_SYSTEM_ID] = ~r.fill;
        words[WORD_STMT_VER] = {r.fill[15:0], r.fill[31:16]};
        if (r.defect == DEF_MAGIC || r.defect == DEF_MULTI)
            words[WORD_MAGIC] ^= 32'd1 << $urandom_range(31);
        if (r.defect == DEF_VERSION)
            words[WORD_VERSION] ^= 32'd1 << $urandom_range(31);
        if (r.defect == DEF_HDR_LEN || r.defect == DEF_MULTI)
            words[WORD_HDR_LEN] ^= 32'd1 << $urandom_range(31);
        if (r.defect == DEF_TOTAL)
            words[WORD_TOTAL] ^= 32'd1 << $urandom_range(31);

        foreach (words[w])
            for (int k = 0; k < 4; k++)
                frame_bytes.push_back(words[w][8*k +: 8]);
        repeat (3 * HASH) frame_bytes.push_back(8'($urandom));
        for (int k = 0; k < 4; k++)
            frame_bytes.push_back(plen[8*k +: 8]);
        repeat (r.n_proof) frame_bytes.push_back(8'($urandom));
        repeat (n_trail) frame_bytes.push_back(8'd0);
        if (r.defect == DEF_TRAILER_NZ)
            frame_bytes[PROOF_AT + r.n_proof + $urandom_range(n_trail - 1)] =
                8'($urandom_range(255, 1));
        if (r.cut != 0)
            while (frame_bytes.size() > r.cut)
                void'(frame_bytes.pop_back());
    endfunction

    // Streams frame_bytes; a typed status replaces the predicted one.
    task automatic send_frame(input bit has_status, input status_t st);
        item_t beat;
        bit    fin;
        int    gap;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            fin = (i == frame_bytes.size() - 1);
            s_tvalid <= 1'b1;
            s_tdata <= frame_bytes[i];
            s_tlast <= fin;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            if (predict_parse(frame_bytes[i], fin, beat)) begin
                if (fin && has_status)
                    beat.status = st;
                pending_fields.push_back(beat);
            end
            gap = pick_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic apb_xfer(input int idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= 3'(4 * idx);
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        // An idle wait with psel low keeps the next transfer's setup apart from this one.
        @(posedge clk);
    endtask

    task automatic check_reg(input int idx, input logic [31:0] want);
        logic [31:0] got;
        apb_xfer(idx, 1'b0, 32'd0, got);
        if (got !== want) begin
            $error("prdata of register %0d: expected %h, got %h", idx, want, got);
            mismatches++;
        end
    endtask

    task automatic set_reg(input int idx, input logic [31:0] val);
        logic [31:0] unused;
        apb_xfer(idx, 1'b1, val, unused);
        if (idx == REG_MAGIC)
            cfg_magic = val;
        else
            cfg_version = val;
        check_reg(idx, val);
    endtask

    // Lets the parser go quiet before the registers change or the run ends.
    task automatic drain_fields();
        s_tvalid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            sink_hold <= pick_gap();
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        item_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_fields.size() == 0) begin
                $error("beat with nothing pending: kind %0d value %h", m_tuser,
                       m_tdata[31:0]);
                mismatches++;
            end else begin
                want = pending_fields.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[31:0] !== want.value) begin
                    $error("value: expected %h, got %h", want.value, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[63:32] !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, m_tdata[63:32]);
                    mismatches++;
                end
                if (m_tdata[66:64] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[66:64]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("proof_frame_checking_parser test failed");
            $finish;
        end
    end

    initial
    begin
        record_t     rec;
        int unsigned sent;
        int          roll;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reg(REG_MAGIC, 32'd0);
        check_reg(REG_VERSION, 32'd2);
        foreach (frame_table[i]) begin
            build_record(frame_table[i]);
            send_frame(frame_table[i].has_status, frame_table[i].status);
        end

        for (int phase = 0; phase < 4; phase++) begin
            drain_fields();
            case (phase)
                0:
                begin
                    set_reg(REG_MAGIC, 32'd0);
                    set_reg(REG_VERSION, 32'hFFFF_FFFF);
                end
                1:
                begin
                    set_reg(REG_MAGIC, 32'hFFFF_FFFF);
                    set_reg(REG_VERSION, 32'd0);
                end
                default:
                begin
                    set_reg(REG_MAGIC, $urandom);
                    set_reg(REG_VERSION, ($urandom_range(1) == 0) ? 32'd2 : $urandom);
                end
            endcase
            no_idle = (phase == 3);
            sent = 0;
            while (sent < 60) begin
                roll = $urandom_range(99);
                rec.defect = (roll < 60) ? DEF_NONE
                                         : defect_t'($urandom_range(DEF_NOISE, DEF_SHORT));
                roll = $urandom_range(99);
                rec.n_proof = (roll < 80) ? $urandom_range(24)
                            : (roll < 95) ? $urandom_range(120, 25)
                                          : $urandom_range(400, 200);
                rec.cut = 0;
                if (rec.defect == DEF_SHORT)
                    rec.cut = $urandom_range(MIN_RECORD - 1, 1);
                else if (rec.defect == DEF_NOISE)
                    rec.cut = $urandom_range(200, 1);
                roll = $urandom_range(9);
                rec.fill = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
                rec.has_status = 1'b0;
                rec.status = ST_OK;
                build_record(rec);
                sent += frame_bytes.size();
                send_frame(1'b0, ST_OK);
            end
        end

        no_idle = 1'b0;
        drain_fields();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("proof_frame_checking_parser test passed");
        else
            $display("proof_frame_checking_parser test failed");
        $finish;
    end

endmodule
